// ===== rtl/fr_pkg.sv =====
// ----------------------------------------------------------------------------
// Fresnel reflectance package
// Widths, constants and the sideband type shared by the pipeline modules.
// ----------------------------------------------------------------------------
package fr_pkg;

   localparam int COMP_W     = 16;
   localparam int INDEX_W    = 14;
   localparam int PROD_W     = 32;
   localparam int DOT_W      = 34;
   localparam int COS_W      = 29;
   localparam int RAD_W      = 57;
   localparam int ROOT_W     = 29;
   localparam int QUOT_W     = 28;
   localparam int NUM_W      = INDEX_W + ROOT_W;
   localparam int AMP_W      = NUM_W + 1;
   localparam int RATIO_BITS = 30;
   localparam int RATIO_W    = RATIO_BITS + 1;
   localparam int SQ_W       = 2 * RATIO_W;
   localparam int OUT_W      = 16;
   localparam int REQ_DATA_W = 128;

   localparam logic signed [DOT_W-1:0] DOT_MAX = 34'sd268435456;
   localparam logic signed [DOT_W-1:0] DOT_MIN = -34'sd268435456;
   localparam logic [RAD_W-1:0]        ONE_Q56 = RAD_W'(1) << 56;
   localparam logic [RATIO_W-1:0]      RATIO_ONE = RATIO_W'(1) << RATIO_BITS;
   localparam logic [OUT_W-1:0]        OUT_ONE = 16'd32768;

   typedef struct packed {
      logic [COS_W-1:0]   c;
      logic [INDEX_W-1:0] etai;
      logic [INDEX_W-1:0] etat;
      logic               tir;
   } fr_side_type;

endpackage

// ===== rtl/fresnel_reflectance_top.sv =====
// Throughput: one word per cycle; the whole pipeline advances together and
// holds while a finished response waits for rsp_tready.
// Depth is set by the two bit-serial square roots and the three dividers.
// Reset is synchronous and clears only the stage valid bits.
// ----------------------------------------------------------------------------
// Fresnel reflectance top level
// Unpolarised Fresnel reflectance with total internal reflection detection.
// ----------------------------------------------------------------------------
module fresnel_reflectance_top
   import fr_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // incident_x, incident_y, incident_z, normal_x, normal_y, normal_z,
   // index_from, index_to, then zero padding.
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // reflectance.
   output logic [OUT_W-1:0]       rsp_tdata,
   // total_reflection.
   output logic                   rsp_tuser
);

   logic adv;

   logic signed [COMP_W-1:0] incident_x, incident_y, incident_z;
   logic signed [COMP_W-1:0] normal_x, normal_y, normal_z;

   logic                      v1_ff;
   logic signed [PROD_W-1:0]  p0_ff, p1_ff, p2_ff;
   logic [INDEX_W-1:0]        from1_ff, to1_ff;

   logic                      v2_ff;
   fr_side_type               side2_ff, side2_in;
   logic signed [DOT_W-1:0]   dot, dot_clamped, dot_mag;

   logic                      v3_ff;
   fr_side_type               side3_ff;
   logic [2*COS_W-1:0]        cc_ff;

   logic                      sq1_valid;
   logic [ROOT_W-1:0]         sin_i;
   fr_side_type               sq1_side;

   logic                      v4_ff;
   logic [NUM_W-1:0]          num_ff;
   fr_side_type               side4_ff;

   logic                      qt_valid;
   logic [QUOT_W-1:0]         sin_t;
   fr_side_type               qt_side;

   logic                      v5_ff;
   logic [2*QUOT_W-1:0]       st2_ff;
   fr_side_type               side5_ff;

   logic                      sq2_valid;
   logic [ROOT_W-1:0]         cos_t;
   fr_side_type               sq2_side;

   logic                      v6_ff, tir6_ff;
   logic [NUM_W-1:0]          as_ff, bs_ff, ap_ff, bp_ff;

   logic                      v7_ff, tir7_ff;
   logic [AMP_W-1:0]          num_s_ff, den_s_ff, num_p_ff, den_p_ff;

   logic                      rt_valid, rt_tir;
   logic [RATIO_W-1:0]        rs, rp;

   logic                      v8_ff, tir8_ff;
   logic [SQ_W-1:0]           rs2_ff, rp2_ff;

   logic                      rsp_valid_ff;
   logic [OUT_W-1:0]          refl_ff, refl_in;
   logic                      tir_out_ff;
   logic [SQ_W:0]             sq_sum, rnd;
   logic [SQ_W-46:0]          refl_w;

   assign adv        = !rsp_valid_ff || rsp_tready;
   assign req_tready = adv;

   assign incident_x = req_tdata[15:0];
   assign incident_y = req_tdata[31:16];
   assign incident_z = req_tdata[47:32];
   assign normal_x   = req_tdata[63:48];
   assign normal_y   = req_tdata[79:64];
   assign normal_z   = req_tdata[95:80];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
         v8_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_tvalid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= sq1_valid;
         v5_ff <= qt_valid;
         v6_ff <= sq2_valid;
         v7_ff <= v6_ff;
         v8_ff <= rt_valid;
         rsp_valid_ff <= v8_ff;
      end
   end

   // The dot product is clamped to one; a positive cosine swaps the media.
   always_comb begin
      dot = DOT_W'(p0_ff) + DOT_W'(p1_ff) + DOT_W'(p2_ff);
      if (dot > DOT_MAX) begin
         dot_clamped = DOT_MAX;
      end else if (dot < DOT_MIN) begin
         dot_clamped = DOT_MIN;
      end else begin
         dot_clamped = dot;
      end
      dot_mag = dot_clamped[DOT_W-1] ? -dot_clamped : dot_clamped;
      side2_in.c   = dot_mag[COS_W-1:0];
      side2_in.tir = 1'b0;
      if (dot_clamped > 0) begin
         side2_in.etai = to1_ff;
         side2_in.etat = from1_ff;
      end else begin
         side2_in.etai = from1_ff;
         side2_in.etat = to1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p0_ff    <= PROD_W'(incident_x) * PROD_W'(normal_x);
         p1_ff    <= PROD_W'(incident_y) * PROD_W'(normal_y);
         p2_ff    <= PROD_W'(incident_z) * PROD_W'(normal_z);
         from1_ff <= req_tdata[109:96];
         to1_ff   <= req_tdata[123:110];
         side2_ff <= side2_in;
         side3_ff <= side2_ff;
         cc_ff    <= (2*COS_W)'(side2_ff.c) * (2*COS_W)'(side2_ff.c);
         num_ff   <= NUM_W'(sq1_side.etai) * NUM_W'(sin_i);
         side4_ff <= sq1_side;
         st2_ff   <= (2*QUOT_W)'(sin_t) * (2*QUOT_W)'(sin_t);
         side5_ff <= qt_side;
         as_ff    <= NUM_W'(sq2_side.etat) * NUM_W'(sq2_side.c);
         bs_ff    <= NUM_W'(sq2_side.etai) * NUM_W'(cos_t);
         ap_ff    <= NUM_W'(sq2_side.etai) * NUM_W'(sq2_side.c);
         bp_ff    <= NUM_W'(sq2_side.etat) * NUM_W'(cos_t);
         tir6_ff  <= sq2_side.tir;
         num_s_ff <= (as_ff > bs_ff) ? AMP_W'(as_ff - bs_ff) : AMP_W'(bs_ff - as_ff);
         den_s_ff <= AMP_W'(as_ff) + AMP_W'(bs_ff);
         num_p_ff <= (ap_ff > bp_ff) ? AMP_W'(ap_ff - bp_ff) : AMP_W'(bp_ff - ap_ff);
         den_p_ff <= AMP_W'(ap_ff) + AMP_W'(bp_ff);
         tir7_ff  <= tir6_ff;
         rs2_ff   <= SQ_W'(rs) * SQ_W'(rs);
         rp2_ff   <= SQ_W'(rp) * SQ_W'(rp);
         tir8_ff  <= rt_tir;
         refl_ff    <= refl_in;
         tir_out_ff <= tir8_ff;
      end
   end

   fr_sqrt u_sqrt_sin (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (v3_ff),
      .in_rad    (ONE_Q56 - cc_ff[RAD_W-1:0]),
      .in_side   (side3_ff),
      .out_valid (sq1_valid),
      .out_root  (sin_i),
      .out_side  (sq1_side)
   );

   fr_quot u_quot (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (v4_ff),
      .in_num    (num_ff),
      .in_side   (side4_ff),
      .out_valid (qt_valid),
      .out_quot  (sin_t),
      .out_side  (qt_side)
   );

   fr_sqrt u_sqrt_cos (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (v5_ff),
      .in_rad    (ONE_Q56 - RAD_W'(st2_ff)),
      .in_side   (side5_ff),
      .out_valid (sq2_valid),
      .out_root  (cos_t),
      .out_side  (sq2_side)
   );

   fr_ratio u_ratio (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (v7_ff),
      .in_num_s  (num_s_ff),
      .in_den_s  (den_s_ff),
      .in_num_p  (num_p_ff),
      .in_den_p  (den_p_ff),
      .in_tir    (tir7_ff),
      .out_valid (rt_valid),
      .out_rs    (rs),
      .out_rp    (rp),
      .out_tir   (rt_tir)
   );

   // Mean of the squares, rounded half up to Q1.15 and saturated at one.
   always_comb begin
      sq_sum = (SQ_W+1)'(rs2_ff) + (SQ_W+1)'(rp2_ff);
      rnd    = (SQ_W+1)'(sq_sum[SQ_W:1]) + ((SQ_W+1)'(1) << 44);
      refl_w = rnd[SQ_W-1:45];
      if (tir8_ff || (refl_w > (SQ_W-45)'(OUT_ONE))) begin
         refl_in = OUT_ONE;
      end else begin
         refl_in = refl_w[OUT_W-1:0];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = refl_ff;
   assign rsp_tuser  = tir_out_ff;

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && tir_out_ff |-> refl_ff == OUT_ONE)
      else $error("total reflection word without full reflectance");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> refl_ff <= OUT_ONE)
      else $error("reflectance above one");

   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid_ff)
      else $error("response valid straight after reset");

   assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(v8_ff) && $stable(rs2_ff))
      else $error("pipeline moved while stalled");
`endif

endmodule

// ===== rtl/fr_sqrt.sv =====
// ----------------------------------------------------------------------------
// Pipelined square root
// Floor square root of a 57-bit radicand, one result bit per stage.
// ----------------------------------------------------------------------------
module fr_sqrt
   import fr_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  logic                in_valid,
   input  logic [RAD_W-1:0]    in_rad,
   input  fr_side_type         in_side,
   output logic                out_valid,
   output logic [ROOT_W-1:0]   out_root,
   output fr_side_type         out_side
);

   logic [ROOT_W:0]     valid_ff;
   logic [RAD_W-1:0]    rem_ff  [ROOT_W+1];
   logic [ROOT_W-1:0]   root_ff [ROOT_W+1];
   fr_side_type         side_ff [ROOT_W+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[ROOT_W-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff[0]  <= in_rad;
         root_ff[0] <= '0;
         side_ff[0] <= in_side;
      end
   end

   for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
      localparam int B = ROOT_W - 1 - k;
      logic [RAD_W+1:0]  trial;
      logic              ge;
      logic [RAD_W-1:0]  rem_in;
      logic [ROOT_W-1:0] root_in;

      always_comb begin
         trial   = ((RAD_W+2)'(root_ff[k]) << (B + 1)) + ((RAD_W+2)'(1) << (2 * B));
         ge      = (RAD_W+2)'(rem_ff[k]) >= trial;
         rem_in  = ge ? rem_ff[k] - trial[RAD_W-1:0] : rem_ff[k];
         root_in = ge ? (root_ff[k] | (ROOT_W'(1) << B)) : root_ff[k];
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[k+1]  <= rem_in;
            root_ff[k+1] <= root_in;
            side_ff[k+1] <= side_ff[k];
         end
      end
   end

   assign out_valid = valid_ff[ROOT_W];
   assign out_root  = root_ff[ROOT_W];
   assign out_side  = side_ff[ROOT_W];

endmodule

// ===== rtl/fr_quot.sv =====
// ----------------------------------------------------------------------------
// Pipelined Snell divider
// Transmitted sine as the quotient of the scaled sine by the target index.
// ----------------------------------------------------------------------------
module fr_quot
   import fr_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  logic                in_valid,
   input  logic [NUM_W-1:0]    in_num,
   input  fr_side_type         in_side,
   output logic                out_valid,
   output logic [QUOT_W-1:0]   out_quot,
   output fr_side_type         out_side
);

   logic [QUOT_W:0]     valid_ff;
   logic [NUM_W-1:0]    rem_ff  [QUOT_W+1];
   logic [QUOT_W-1:0]   quot_ff [QUOT_W+1];
   fr_side_type         side_ff [QUOT_W+1];
   fr_side_type         side_in;

   // A quotient of one or more, or a zero divisor, is total reflection.
   always_comb begin
      side_in     = in_side;
      side_in.tir = in_side.tir || (in_side.etat == '0) ||
                    (in_num >= (NUM_W'(in_side.etat) << QUOT_W));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[QUOT_W-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff[0]  <= in_num;
         quot_ff[0] <= '0;
         side_ff[0] <= side_in;
      end
   end

   for (genvar k = 0; k < QUOT_W; k++) begin : g_stage
      localparam int B = QUOT_W - 1 - k;
      logic [NUM_W-1:0] trial;
      logic             ge;

      always_comb begin
         trial = NUM_W'(side_ff[k].etat) << B;
         ge    = rem_ff[k] >= trial;
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[k+1]  <= ge ? rem_ff[k] - trial : rem_ff[k];
            quot_ff[k+1] <= ge ? (quot_ff[k] | (QUOT_W'(1) << B)) : quot_ff[k];
            side_ff[k+1] <= side_ff[k];
         end
      end
   end

   assign out_valid = valid_ff[QUOT_W];
   assign out_quot  = quot_ff[QUOT_W];
   assign out_side  = side_ff[QUOT_W];

endmodule

// ===== rtl/fr_ratio.sv =====
// ----------------------------------------------------------------------------
// Pipelined amplitude ratio dividers
// The s and p ratios |a - b| / (a + b) in Q1.30, one quotient bit per stage.
// ----------------------------------------------------------------------------
module fr_ratio
   import fr_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  logic                 in_valid,
   input  logic [AMP_W-1:0]     in_num_s,
   input  logic [AMP_W-1:0]     in_den_s,
   input  logic [AMP_W-1:0]     in_num_p,
   input  logic [AMP_W-1:0]     in_den_p,
   input  logic                 in_tir,
   output logic                 out_valid,
   output logic [RATIO_W-1:0]   out_rs,
   output logic [RATIO_W-1:0]   out_rp,
   output logic                 out_tir
);

   logic [RATIO_BITS:0]     valid_ff;
   logic [RATIO_BITS:0]     tir_ff;
   logic [RATIO_BITS:0]     full_s_ff;
   logic [RATIO_BITS:0]     full_p_ff;
   logic [AMP_W-1:0]        rem_s_ff [RATIO_BITS+1];
   logic [AMP_W-1:0]        rem_p_ff [RATIO_BITS+1];
   logic [AMP_W-1:0]        den_s_ff [RATIO_BITS+1];
   logic [AMP_W-1:0]        den_p_ff [RATIO_BITS+1];
   logic [RATIO_BITS-1:0]   q_s_ff   [RATIO_BITS+1];
   logic [RATIO_BITS-1:0]   q_p_ff   [RATIO_BITS+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[RATIO_BITS-1:0], in_valid};
      end
   end

   // A numerator not below its denominator gives a ratio of one.
   always_ff @(posedge clock) begin
      if (adv) begin
         tir_ff    <= {tir_ff[RATIO_BITS-1:0], in_tir};
         full_s_ff <= {full_s_ff[RATIO_BITS-1:0], in_num_s >= in_den_s};
         full_p_ff <= {full_p_ff[RATIO_BITS-1:0], in_num_p >= in_den_p};
         rem_s_ff[0] <= in_num_s;
         rem_p_ff[0] <= in_num_p;
         den_s_ff[0] <= in_den_s;
         den_p_ff[0] <= in_den_p;
         q_s_ff[0]   <= '0;
         q_p_ff[0]   <= '0;
      end
   end

   for (genvar k = 0; k < RATIO_BITS; k++) begin : g_stage
      logic [AMP_W:0] r2_s;
      logic [AMP_W:0] r2_p;
      logic           ge_s;
      logic           ge_p;
      logic [AMP_W:0] nr_s;
      logic [AMP_W:0] nr_p;

      always_comb begin
         r2_s = {rem_s_ff[k], 1'b0};
         r2_p = {rem_p_ff[k], 1'b0};
         ge_s = r2_s >= {1'b0, den_s_ff[k]};
         ge_p = r2_p >= {1'b0, den_p_ff[k]};
         nr_s = ge_s ? r2_s - {1'b0, den_s_ff[k]} : r2_s;
         nr_p = ge_p ? r2_p - {1'b0, den_p_ff[k]} : r2_p;
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_s_ff[k+1] <= nr_s[AMP_W-1:0];
            rem_p_ff[k+1] <= nr_p[AMP_W-1:0];
            den_s_ff[k+1] <= den_s_ff[k];
            den_p_ff[k+1] <= den_p_ff[k];
            q_s_ff[k+1]   <= {q_s_ff[k][RATIO_BITS-2:0], ge_s};
            q_p_ff[k+1]   <= {q_p_ff[k][RATIO_BITS-2:0], ge_p};
         end
      end
   end

   assign out_valid = valid_ff[RATIO_BITS];
   assign out_tir   = tir_ff[RATIO_BITS];
   assign out_rs    = full_s_ff[RATIO_BITS] ? RATIO_ONE : {1'b0, q_s_ff[RATIO_BITS]};
   assign out_rp    = full_p_ff[RATIO_BITS] ? RATIO_ONE : {1'b0, q_p_ff[RATIO_BITS]};

endmodule

// ===== tb/fresnel_reflectance_top_tb.sv =====
// ----------------------------------------------------------------------------
// Fresnel reflectance testbench
// Drives request words with random gaps, predicts each reflectance in
// fixed point and checks the response words in order against it.
// ----------------------------------------------------------------------------
module fresnel_reflectance_top_tb
   import fr_pkg::*;
();

   localparam int LATENCY    = 129;
   localparam int IDLE_LIMIT = 20000;
   localparam int N_RANDOM   = 1500;

   typedef struct {
      logic [15:0] ix, iy, iz, nx, ny, nz;
      logic [13:0] eta_from, eta_to;
   } ray_type;

   typedef struct {
      logic [15:0] refl;
      logic        tir;
      logic        known;
   } shade_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [OUT_W-1:0]      rsp_tdata;
   logic                  rsp_tuser;

   shade_type expected_shades[$];
   ray_type   table_rays[$];
   shade_type table_shades[$];
   int        mismatches = 0;
   int        idle_cycles = 0;
   bit        long_hold = 1'b0;

   fresnel_reflectance_top DUT (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic logic [63:0] floor_sqrt(logic [63:0] v);
      logic [63:0] res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic logic [63:0] amp_ratio(logic [63:0] num, logic [63:0] den);
      logic [127:0] wide;
      if (num >= den) return 64'd1 << RATIO_BITS;
      wide = {64'd0, num} << RATIO_BITS;
      wide = wide / {64'd0, den};
      return wide[63:0];
   endfunction

   function automatic shade_type predict_shade(ray_type r);
      shade_type   s;
      longint      dot;
      logic [63:0] c, sin_i, st, cost, ei, et, a, b, rs, rp, sum, refl;
      dot = longint'($signed(r.ix)) * $signed(r.nx) + longint'($signed(r.iy)) * $signed(r.ny)
          + longint'($signed(r.iz)) * $signed(r.nz);
      if (dot > (64'sd1 << 28)) dot = 64'sd1 << 28;
      if (dot < -(64'sd1 << 28)) dot = -(64'sd1 << 28);
      ei = 64'(r.eta_from);
      et = 64'(r.eta_to);
      if (dot > 0) begin
         ei = 64'(r.eta_to);
         et = 64'(r.eta_from);
         c = dot;
      end else begin
         c = -dot;
      end
      s.known = 1'b1;
      s.refl = OUT_ONE;
      s.tir = 1'b1;
      sin_i = floor_sqrt((64'd1 << 56) - c * c);
      if (et == 0) return s;
      st = (ei * sin_i) / et;
      if (st >= (64'd1 << 28)) return s;
      cost = floor_sqrt((64'd1 << 56) - st * st);
      a = et * c;
      b = ei * cost;
      rs = amp_ratio(a > b ? a - b : b - a, a + b);
      a = ei * c;
      b = et * cost;
      rp = amp_ratio(a > b ? a - b : b - a, a + b);
      sum = (rs * rs + rp * rp) >> 1;
      refl = (sum + (64'd1 << 44)) >> 45;
      if (refl > OUT_ONE) refl = OUT_ONE;
      s.refl = refl[15:0];
      s.tir = 1'b0;
      return s;
   endfunction

   function automatic logic [15:0] rand_comp();
      case ($urandom_range(0, 9))
         0: return 16'sd16384;
         1: return -16'sd16384;
         2: return 16'($urandom);
         default: return 16'($signed($urandom_range(0, 32768)) - 16384);
      endcase
   endfunction

   function automatic logic [13:0] rand_index();
      if ($urandom_range(0, 5) == 0) return 14'($urandom);
      return 14'($urandom_range(4096, 8192));
   endfunction

   function automatic ray_type rand_ray();
      ray_type r;
      r.ix = rand_comp();
      r.iy = rand_comp();
      r.iz = rand_comp();
      r.nx = rand_comp();
      r.ny = rand_comp();
      r.nz = rand_comp();
      r.eta_from = rand_index();
      r.eta_to = rand_index();
      return r;
   endfunction

   function automatic void add_row(ray_type r, shade_type s);
      table_rays.insert(table_rays.size(), r);
      table_shades.insert(table_shades.size(), s);
   endfunction

   task automatic send_ray(ray_type r, shade_type fixed);
      shade_type s;
      s = predict_shade(r);
      if (fixed.known) s = fixed;
      req_tvalid <= 1'b1;
      req_tdata <= {4'd0, r.eta_to, r.eta_from, r.nz, r.ny, r.nx, r.iz, r.iy, r.ix};
      do @(posedge clock); while (!req_tready);
      expected_shades.insert(expected_shades.size(), s);
   endtask

   task automatic sender_gap();
      int n;
      n = $urandom_range(0, 9) < 6 ? 0 : ($urandom_range(0, 9) == 0 ?
          $urandom_range(20, 200) : $urandom_range(1, 4));
      if (n > 0) begin
         req_tvalid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   initial begin
      shade_type none, fix, graze;
      none = '{refl: 0, tir: 0, known: 0};
      fix = '{refl: OUT_ONE, tir: 1'b1, known: 1'b1};
      graze = '{refl: OUT_ONE, tir: 1'b0, known: 1'b1};
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      // Head-on hit from air into glass, and the ray leaving the glass.
      add_row('{0, 0, -16384, 0, 0, 16384, 4096, 6144}, none);
      add_row('{0, 0, 16384, 0, 0, 16384, 4096, 6144}, none);
      // Grazing exit from a dense medium is totally reflected.
      add_row('{16384, 0, 1000, 0, 0, 16384, 4096, 16383}, fix);
      // A ray along the surface reflects fully without the flag.
      add_row('{16384, 0, 0, 0, 0, 16384, 4096, 16383}, graze);
      // Zero index on the far side.
      add_row('{0, 0, -8000, 0, 0, 16384, 4096, 0}, fix);
      add_row('{0, 0, 8000, 0, 0, 16384, 0, 4096}, fix);
      // Matched indices and both indices zero.
      add_row('{5000, -3000, -9000, 0, 0, 16384, 8192, 8192}, none);
      add_row('{0, 0, 0, 0, 0, 0, 0, 0}, fix);
      // Unnormalised vectors that need the clamp, and bit-pattern extremes.
      add_row('{16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff,
                14'h3fff, 14'h3fff}, none);
      add_row('{16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
                14'h1000, 14'h3fff}, none);
      add_row('{16'hffff, 16'hffff, 16'hffff, 16'h0001, 16'h0001, 16'h0001,
                14'h3fff, 14'h1000}, none);
      add_row('{-16384, 0, 0, 16384, 0, 0, 16383, 4096}, none);
      add_row('{11585, 0, -11585, 0, 0, 16384, 4096, 16383}, none);
      foreach (table_rays[i]) send_ray(table_rays[i], table_shades[i]);
      for (int i = 0; i < N_RANDOM; i++) begin
         if (i == N_RANDOM / 3) begin
            long_hold = 1'b1;
         end
         if (i == 2 * N_RANDOM / 3) begin
            req_tvalid <= 1'b0;
            wait (expected_shades.size() == 0);
            @(posedge clock);
         end
         send_ray(rand_ray(), none);
         sender_gap();
      end
      req_tvalid <= 1'b0;
      wait (expected_shades.size() == 0);
      repeat (LATENCY + 20) @(posedge clock);
      if (mismatches == 0) begin
         $display("fresnel_reflectance_top_tb: clean");
      end else begin
         $display("fresnel_reflectance_top_tb: errors");
      end
      $finish;
   end

   // The receiver stalls at random, and once for long enough to fill the pipeline.
   initial begin
      int n;
      forever begin
         @(posedge clock);
         if (long_hold) begin
            long_hold = 1'b0;
            rsp_tready <= 1'b0;
            repeat (400) @(posedge clock);
         end
         n = $urandom_range(0, 9);
         if (n < 2) begin
            rsp_tready <= 1'b0;
         end else if (n == 2 && $urandom_range(0, 9) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(20, 150)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      shade_type s;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_shades.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response word: refl %0d tir %0b", rsp_tdata, rsp_tuser);
         end else begin
            s = expected_shades.pop_front();
            if (rsp_tdata !== s.refl || rsp_tuser !== s.tir) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected refl %0d tir %0b, got refl %0d tir %0b",
                           s.refl, s.tir, rsp_tdata, rsp_tuser);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("fresnel_reflectance_top_tb: errors");
         $finish;
      end
   end

endmodule
